// File: rtl/crc32c_gf2_mul_pow_shift_macros.svh
// assertion macros shared by the checker of the crc32c gf(2) block
// needs a clk and an arst_n in the scope where a macro is used
`ifndef CRC32C_GF2_MUL_POW_SHIFT_MACROS_SVH
`define CRC32C_GF2_MUL_POW_SHIFT_MACROS_SVH

// property checked on every rising clk edge, quiet while in reset
`define CRC_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same, but the consequence must hold in the cycle after the trigger
`define CRC_ASSERT_NEXT(label, trig, cons, msg) \
	`CRC_ASSERT_CLK(label, (trig) |=> (cons), msg)

`endif

// File: rtl/crc32c_pkg.sv
// package for the crc32c gf(2) multiply, power and shift block
// holds polynomial constants, request codes and the squaring tables
// no dependencies
package crc32c_pkg;

	localparam logic [31:0] POLY      = 32'h82F6_3B78;
	localparam logic [31:0] X_POW_0   = 32'h8000_0000;
	localparam logic [31:0] X_POW_1   = 32'h4000_0000;
	localparam int          TBL_DEPTH = 31;
	localparam int          IDX_W     = 5;

	localparam logic [1:0] REQ_MUL    = 2'd0;
	localparam logic [1:0] REQ_POW    = 2'd1;
	localparam logic [1:0] REQ_SHIFT  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef logic [TBL_DEPTH-1:0][31:0] tbl_t;

	// full 32-step multiply, only evaluated at elaboration for the tables
	function automatic logic [31:0] gf_mul_f(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] acc;
		logic [31:0] bb;
		acc = '0;
		bb  = b;
		for (int n = 0; n < 32; n++) begin
			acc = (acc >> 1) ^ (acc[0] ? POLY : 32'h0) ^ (bb[0] ? a : 32'h0);
			bb  = bb >> 1;
		end
		return acc;
	endfunction

	// x^(2^i)
	function automatic tbl_t sq_table_f();
		tbl_t        t;
		logic [31:0] x;
		x    = X_POW_1;
		t[0] = x;
		for (int i = 1; i < TBL_DEPTH; i++) begin
			x    = gf_mul_f(x, x);
			t[i] = x;
		end
		return t;
	endfunction

	// x^(-2^i), entry 0 is x^(2^32-3)
	function automatic tbl_t inv_table_f();
		tbl_t        sq;
		tbl_t        t;
		logic [31:0] x;
		logic [31:0] mag;
		int          j;
		sq  = sq_table_f();
		mag = 32'hFFFF_FFFD;
		x   = X_POW_0;
		for (int k = 0; k < 32; k++) begin
			j = (k < TBL_DEPTH) ? k : k - TBL_DEPTH;
			if (mag[k]) begin
				x = gf_mul_f(x, sq[j]);
			end
		end
		t[0] = x;
		for (int i = 1; i < TBL_DEPTH; i++) begin
			x    = gf_mul_f(x, x);
			t[i] = x;
		end
		return t;
	endfunction

	localparam tbl_t SQ_TBL  = sq_table_f();
	localparam tbl_t INV_TBL = inv_table_f();

endpackage

// File: rtl/crc32c_gf2_mul_pow_shift.sv
// GF(2) arithmetic modulo the reflected CRC32C polynomial: one result beat per
// request beat. Mode 0 multiplies operand_a by operand_b, mode 1 returns x^p, mode 2
// returns operand_a * x^p, mode 3 returns zero. Bit 31 of every word is x^0. All work
// runs through one multiply unit that retires eight reduction steps per cycle, save
// when the last step of a final multiply waits for a held output. A power or shift
// request scans |p| one bit per cycle and runs a modular multiply by a table entry on
// each set bit, and in shift mode one more multiply by operand_a at the end. Mode 3
// writes zero straight into the result register, or waits in the scan state while
// the output is held. The next request is taken the cycle after a result is written.
// Results wait in an output register, so s_tready does not depend on m_tready; the
// unit only stalls when a new result is ready while the previous beat is still held.
// Depends on crc32c_pkg.
module crc32c_gf2_mul_pow_shift (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type[1:0], operand_a[33:2], operand_b[65:34], shift_amount[129:66], zero pad
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result[31:0]
	output logic [31:0]  m_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL
	} state_t;

	state_t                         state_q;
	logic [1:0]                     type_q;
	logic [31:0]                    a_q;
	logic [63:0]                    mag_q;
	logic                           neg_q;
	logic [crc32c_pkg::IDX_W-1:0]   idx_q;
	logic [31:0]                    prod_q;
	logic [31:0]                    mc_q;
	logic [31:0]                    mb_q;
	logic [31:0]                    acc_q;
	logic [1:0]                     step_q;
	logic                           fin_q;
	logic [31:0]                    res_q;
	logic                           vld_q;

	logic [1:0]  in_type;
	logic [31:0] in_a;
	logic [31:0] in_b;
	logic [63:0] in_p;
	logic [63:0] in_mag;
	logic        accept;
	logic        out_free;
	logic        res_load;
	logic [31:0] acc_nxt;
	logic [31:0] tbl_entry;
	logic [crc32c_pkg::IDX_W-1:0] idx_nxt;

	assign in_type = s_tdata[1:0];
	assign in_a    = s_tdata[33:2];
	assign in_b    = s_tdata[65:34];
	assign in_p    = s_tdata[129:66];
	// most negative p wraps onto itself, leaving only bit 63 set
	assign in_mag  = in_p[63] ? (64'd0 - in_p) : in_p;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = vld_q;
	assign m_tdata  = res_q;
	assign accept   = s_tvalid && s_tready;
	// the result register can take a new word in the cycle its beat leaves
	assign out_free = !vld_q || m_tready;
	assign res_load = out_free && (
		(accept && (in_type == crc32c_pkg::REQ_UNUSED))
		|| ((state_q == ST_SCAN) && (mag_q == 64'd0) && (type_q != crc32c_pkg::REQ_SHIFT))
		|| ((state_q == ST_MUL) && (step_q == 2'd3) && fin_q));

	assign tbl_entry = neg_q ? crc32c_pkg::INV_TBL[idx_q] : crc32c_pkg::SQ_TBL[idx_q];
	assign idx_nxt   = (idx_q == crc32c_pkg::IDX_W'(crc32c_pkg::TBL_DEPTH - 1))
		? '0 : idx_q + 1'b1;

	// shared multiply unit: eight shift and conditional-xor steps per cycle
	always_comb begin
		acc_nxt = acc_q;
		for (int i = 0; i < 8; i++) begin
			acc_nxt = (acc_nxt >> 1) ^ (acc_nxt[0] ? crc32c_pkg::POLY : 32'h0)
				^ (mb_q[i] ? mc_q : 32'h0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			type_q  <= '0;
			a_q     <= '0;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			idx_q   <= '0;
			prod_q  <= '0;
			mc_q    <= '0;
			mb_q    <= '0;
			acc_q   <= '0;
			step_q  <= '0;
			fin_q   <= 1'b0;
			res_q   <= '0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= res_load || (vld_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						type_q <= in_type;
						a_q    <= in_a;
						neg_q  <= in_p[63];
						idx_q  <= '0;
						unique case (in_type) inside
							crc32c_pkg::REQ_MUL: begin
								mc_q    <= in_a;
								mb_q    <= in_b;
								acc_q   <= '0;
								step_q  <= '0;
								fin_q   <= 1'b1;
								state_q <= ST_MUL;
							end
							crc32c_pkg::REQ_POW, crc32c_pkg::REQ_SHIFT: begin
								mag_q   <= in_mag;
								prod_q  <= crc32c_pkg::X_POW_0;
								state_q <= ST_SCAN;
							end
							default: begin
								// zero answer, waits in the scan while the output is held
								mag_q  <= '0;
								prod_q <= '0;
								if (out_free) begin
									res_q <= '0;
								end else begin
									state_q <= ST_SCAN;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (mag_q == 64'd0) begin
						if (type_q == crc32c_pkg::REQ_SHIFT) begin
							mc_q    <= a_q;
							mb_q    <= prod_q;
							acc_q   <= '0;
							step_q  <= '0;
							fin_q   <= 1'b1;
							state_q <= ST_MUL;
						end else if (out_free) begin
							res_q   <= prod_q;
							state_q <= ST_IDLE;
						end
					end else begin
						if (mag_q[0]) begin
							mc_q    <= prod_q;
							mb_q    <= tbl_entry;
							acc_q   <= '0;
							step_q  <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_MUL;
						end
						mag_q <= mag_q >> 1;
						idx_q <= idx_nxt;
					end
				end
				ST_MUL: begin
					// the last step of a final multiply holds until the output is free
					if ((step_q != 2'd3) || !fin_q || out_free) begin
						acc_q  <= acc_nxt;
						mb_q   <= mb_q >> 8;
						step_q <= step_q + 1'b1;
						if (step_q == 2'd3) begin
							if (fin_q) begin
								res_q   <= acc_nxt;
								state_q <= ST_IDLE;
							end else begin
								prod_q  <= acc_nxt;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/crc32c_chk.sv
// port-level checker for crc32c_gf2_mul_pow_shift, bound to the top level
// depends on crc32c_pkg and crc32c_gf2_mul_pow_shift_macros.svh
`include "crc32c_gf2_mul_pow_shift_macros.svh"

module crc32c_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [135:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [31:0]  m_tdata
);

	logic in_beat;
	logic out_beat;
	logic stalled;
	logic unused_beat;
	logic mul_beat;
	logic idle_beat;

	assign in_beat     = s_tvalid && s_tready;
	assign out_beat    = m_tvalid && m_tready;
	assign stalled     = m_tvalid && !m_tready;
	assign unused_beat = in_beat && (s_tdata[1:0] == crc32c_pkg::REQ_UNUSED)
		&& (!m_tvalid || m_tready);
	assign mul_beat    = in_beat && (s_tdata[1:0] == crc32c_pkg::REQ_MUL);
	assign idle_beat   = out_beat && s_tready && !s_tvalid;

	// handshake outputs are always known outside reset
	`CRC_ASSERT_CLK(a_known, !$isunknown({s_tready, m_tvalid}), "handshake unknown")
	// a stalled result beat holds
	`CRC_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "stalled beat changed")
	// unused mode answers zero at once when the output is free
	`CRC_ASSERT_NEXT(a_unused, unused_beat, m_tvalid && (m_tdata == 32'h0), "unused not zero")
	// a multiply occupies the shared unit, so a taken multiply drops s_tready
	`CRC_ASSERT_NEXT(a_mul_busy, mul_beat, !s_tready, "ready during multiply")
	// the last beat taken with nothing in flight leaves the output empty
	`CRC_ASSERT_NEXT(a_drained, idle_beat, !m_tvalid, "valid after last beat")

endmodule

bind crc32c_gf2_mul_pow_shift crc32c_chk u_chk (.*);
